FILE: design/lcl_pkg.sv
// ============================================================================
// lcl_pkg
// Shared types and constants of the LED frame current limiter: frame size,
// counter and datapath widths, register indexes, sequencer states and the
// request bundle of the scale divider.
// ============================================================================
`default_nettype none

package lcl_pkg;

   // Frame capacity and the widths that follow from it.
   localparam int MAX_LEDS = 64;
   localparam int IDX_W    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int CNT_W    = $clog2(MAX_LEDS + 1);

   // Datapath widths.
   localparam int CHAN_W   = 8;
   localparam int PIXEL_W  = 3 * CHAN_W;
   localparam int SUM_W    = 16;
   localparam int LIMIT_W  = 16;
   localparam int WHITE_W  = 8;
   localparam int IDLE_W   = 4;
   localparam int QUIET_W  = CNT_W + IDLE_W;
   localparam int PROD_W   = SUM_W + WHITE_W;
   localparam int DRAW_W   = 16;

   // Draw estimate divisor: one LED at full white sums to three full bytes.
   localparam int FULL_SUM = 765;

   // The division by 765 is a multiplication by a rounded-up reciprocal of
   // 2^33 / 765. The reciprocal overshoots by 253 / 2^33 per unit, which
   // keeps the quotient exact for every draw product below 2^24.
   localparam int DRAW_SHIFT = 33;
   localparam logic [PROD_W-1:0] DRAW_RECIP =
      PROD_W'(((64'd1 << DRAW_SHIFT) + 64'(FULL_SUM) - 64'd1) / 64'(FULL_SUM));

   // Scale divider geometry.
   localparam int DIV_N_W  = 24;
   localparam int DIV_D_W  = 16;
   localparam int DIV_C_W  = $clog2(DIV_N_W);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WHITE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE  = 2'd2;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MUL,
      ST_DRAW,
      ST_DECIDE,
      ST_SCALE_GO,
      ST_SCALE_WAIT,
      ST_EMIT
   } lcl_state_type;

   // Request to the scale divider.
   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } lcl_div_req_type;

endpackage : lcl_pkg

`default_nettype wire

FILE: design/lcl_div.sv
// ============================================================================
// lcl_div
// Restoring divider that computes the frame scale factor.
// One quotient bit per cycle; done pulses when the quotient is complete.
// ============================================================================
`default_nettype none

module lcl_div
   import lcl_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lcl_div_req_type    req,
   output logic                    done,
   output logic [DIV_N_W-1:0]      quotient
);

   logic               busy_ff,  busy_in;
   logic               done_ff,  done_in;
   logic [DIV_C_W-1:0] cnt_ff,   cnt_in;
   logic [DIV_N_W-1:0] quo_ff,   quo_in;
   logic [DIV_D_W-1:0] rem_ff,   rem_in;
   logic [DIV_D_W-1:0] dsr_ff,   dsr_in;

   logic [DIV_D_W:0]   trial;
   logic [DIV_D_W:0]   diff;
   logic               fits;

   // One restoring step: bring down the next dividend bit and try a subtract.
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_N_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      fits  = (trial >= {1'b0, dsr_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_N_W-2:0], fits};
         rem_in = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
         cnt_in = cnt_ff + DIV_C_W'(1);
         if (cnt_ff == DIV_C_W'(DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule : lcl_div

`default_nettype wire

FILE: design/lcl_lane.sv
// ============================================================================
// lcl_lane
// One color lane: scales a channel byte by the frame scale factor,
// (byte * scale) >> 8, or passes it through when the frame is not dimmed.
// ============================================================================
`default_nettype none

module lcl_lane
   import lcl_pkg::*;
(
   input  wire logic [CHAN_W-1:0] chan,
   input  wire logic [CHAN_W-1:0] scale,
   input  wire logic              scale_on,
   output logic      [CHAN_W-1:0] result
);

   logic [2*CHAN_W-1:0] prod;

   // The upper byte of the product is the shift right by eight.
   always_comb begin
      prod   = (2*CHAN_W)'(chan) * (2*CHAN_W)'(scale);
      result = scale_on ? prod[2*CHAN_W-1:CHAN_W] : chan;
   end

endmodule : lcl_lane

`default_nettype wire

FILE: design/led_frame_current_limiter.sv
// ============================================================================
// led_frame_current_limiter
// Stores an LED frame, estimates its current draw and, for a nonzero limit
// and a draw over budget, dims every channel byte by one common scale factor.
// ============================================================================
// LEDs are loaded one word per cycle into a 64-entry frame memory while the
// channel bytes are summed; words past 64 are dropped and flagged. After the
// word marked last, the block computes the draw product, then divides it by
// 765, done as a multiplication by a fixed reciprocal, and then compares the
// draw with the budget. Only when the frame must be dimmed does it then work
// out the scale factor: a start state, then the bit-serial divider, which
// finds one quotient bit at a time, and the hand-over of its result. It then
// emits the stored frame one word per cycle while the output is ready,
// through three parallel color lanes; each word goes through the memory
// read register and then the output register. The input is not ready
// during computation and emission. Configuration writes are taken at any
// time but must only occur while idle.
`default_nettype none

module led_frame_current_limiter
   import lcl_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Input words: green [7:0], red [15:8], blue [23:16].
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [PIXEL_W-1:0]   req_tdata,
   input  wire logic                 req_tlast,
   // Result words: out_green [7:0], out_red [15:8], out_blue [23:16].
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic      [PIXEL_W-1:0]   rsp_tdata,
   output logic                      rsp_tlast,
   // Result flags: dimmed [0], overflowed [1].
   output logic      [1:0]           rsp_tuser,
   // Configuration write port.
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [LIMIT_W-1:0]   csr_wdata
);

   // Configuration registers.
   logic [LIMIT_W-1:0] limit_ff;
   logic [WHITE_W-1:0] white_ff;
   logic [IDLE_W-1:0]  idle_ff;

   // Sequencer and frame accumulation.
   lcl_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   count_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic               ovf_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [LIMIT_W-1:0] budget_ff;
   logic [DRAW_W-1:0]  draw_ff;
   logic [CHAN_W-1:0]  scale_ff;
   logic               dim_ff;

   // Emission pipeline.
   logic [CNT_W-1:0]   issue_ff;
   logic [CNT_W-1:0]   sent_ff;
   logic               rd_valid_ff;
   logic [PIXEL_W-1:0] rd_data_ff;
   logic               rsp_valid_ff;
   logic [PIXEL_W-1:0] rsp_data_ff;
   logic               rsp_last_ff;
   logic [1:0]         rsp_user_ff;

   logic [PIXEL_W-1:0] frame_mem [MAX_LEDS];

   logic                accept;
   logic                store;
   logic                rd_en;
   logic                load_out;
   logic                frame_end;
   logic                emitting;
   logic [QUIET_W-1:0]  quiet;
   logic [LIMIT_W-1:0]  budget;
   logic                need_dim;
   logic [2*PROD_W-1:0] draw_prod;
   logic [PIXEL_W-1:0]  lane_out;
   lcl_div_req_type     div_req;
   logic                div_done;
   logic [DIV_N_W-1:0]  div_quo;

   // Configuration writes; an unknown index is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
         white_ff <= WHITE_W'(60);
         idle_ff  <= IDLE_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_LIMIT: limit_ff <= csr_wdata;
            CSR_WHITE: white_ff <= csr_wdata[WHITE_W-1:0];
            CSR_IDLE:  idle_ff  <= csr_wdata[IDLE_W-1:0];
            default:   ;
         endcase
      end
   end

   // Handshake qualifiers.
   always_comb begin
      accept    = req_tvalid && req_tready;
      store     = accept && (count_ff < CNT_W'(MAX_LEDS));
      load_out  = rd_valid_ff && (!rsp_valid_ff || rsp_tready);
      rd_en     = emitting && (issue_ff < count_ff) && (!rd_valid_ff || load_out);
      frame_end = load_out && (sent_ff == count_ff - CNT_W'(1));
   end

   // Budget: the cap less the idle draw of the stored LEDs, floored at zero.
   always_comb begin
      quiet    = QUIET_W'(count_ff) * QUIET_W'(idle_ff);
      budget   = (limit_ff > LIMIT_W'(quiet)) ? limit_ff - LIMIT_W'(quiet) : '0;
      need_dim = (limit_ff != '0) && (draw_ff != '0) && (draw_ff > budget_ff);
   end

   // Draw estimate: the product divided by 765 through the fixed reciprocal.
   always_comb begin
      draw_prod = (2*PROD_W)'(prod_ff) * (2*PROD_W)'(DRAW_RECIP);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:       if (accept && req_tlast) state_in = ST_MUL;
         ST_MUL:        state_in = ST_DRAW;
         ST_DRAW:       state_in = ST_DECIDE;
         ST_DECIDE:     state_in = need_dim ? ST_SCALE_GO : ST_EMIT;
         ST_SCALE_GO:   state_in = ST_SCALE_WAIT;
         ST_SCALE_WAIT: if (div_done) state_in = ST_EMIT;
         ST_EMIT:       if (frame_end) state_in = ST_LOAD;
         default:       state_in = ST_LOAD;
      endcase
   end

   // State outputs.
   always_comb begin
      req_tready       = 1'b0;
      emitting         = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = DIV_N_W'({budget_ff, 8'h00});
      div_req.divisor  = DIV_D_W'(draw_ff);
      case (state_ff)
         ST_LOAD:     req_tready    = 1'b1;
         ST_SCALE_GO: div_req.start = 1'b1;
         ST_EMIT:     emitting      = 1'b1;
         default:     ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Frame accumulation; cleared once the last word enters the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
         dim_ff   <= 1'b0;
      end else begin
         if (frame_end) begin
            count_ff <= '0;
            sum_ff   <= '0;
            ovf_ff   <= 1'b0;
         end else if (store) begin
            count_ff <= count_ff + CNT_W'(1);
            sum_ff   <= sum_ff + SUM_W'(req_tdata[7:0]) + SUM_W'(req_tdata[15:8])
                        + SUM_W'(req_tdata[23:16]);
         end else if (accept) begin
            ovf_ff <= 1'b1;
         end
         if (state_ff == ST_DECIDE) begin
            dim_ff <= need_dim;
         end
      end
   end

   // Draw product, budget, draw and scale results.
   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_ff   <= PROD_W'(sum_ff) * PROD_W'(white_ff);
         budget_ff <= budget;
      end
      if (state_ff == ST_DRAW) begin
         draw_ff <= DRAW_W'(draw_prod >> DRAW_SHIFT);
      end
      if (state_ff == ST_SCALE_WAIT && div_done) begin
         scale_ff <= div_quo[CHAN_W-1:0];
      end
   end

   lcl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Frame memory: written while loading, read during emission.
   always_ff @(posedge clock) begin
      if (store) begin
         frame_mem[count_ff[IDX_W-1:0]] <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= frame_mem[issue_ff[IDX_W-1:0]];
      end
   end

   // Read issue and delivery counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff    <= '0;
         sent_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (frame_end) begin
            issue_ff <= '0;
            sent_ff  <= '0;
         end else begin
            if (rd_en) begin
               issue_ff <= issue_ff + CNT_W'(1);
            end
            if (load_out) begin
               sent_ff <= sent_ff + CNT_W'(1);
            end
         end
         if (rd_en) begin
            rd_valid_ff <= 1'b1;
         end else if (load_out) begin
            rd_valid_ff <= 1'b0;
         end
      end
   end

   // Three color lanes scale one stored word side by side.
   for (genvar c = 0; c < 3; c++) begin : g_lane
      lcl_lane u_lane (
         .chan     (rd_data_ff[c*CHAN_W +: CHAN_W]),
         .scale    (scale_ff),
         .scale_on (dim_ff),
         .result   (lane_out[c*CHAN_W +: CHAN_W])
      );
   end

   // Merge the lanes into the output register with frame flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= lane_out;
         rsp_last_ff <= (sent_ff == count_ff - CNT_W'(1));
         rsp_user_ff <= {ovf_ff, dim_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule : led_frame_current_limiter

`default_nettype wire
